// File: src/imu_serial_frame_decoder_top_defines.svh
// Assertion macros shared by the IMU serial frame decoder RTL.
`ifndef IMU_SERIAL_FRAME_DECODER_TOP_DEFINES_SVH
`define IMU_SERIAL_FRAME_DECODER_TOP_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SFD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define SFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define SFD_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define SFD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// File: src/imu_sfd_pkg.sv
// Package with constants and types of the IMU serial frame decoder.
package imu_sfd_pkg;

    localparam int BYTE_W      = 8;
    localparam int RAW_W       = 16;
    localparam int WIN_DEPTH   = 31;
    localparam int SEQ_LEN     = WIN_DEPTH + 1;
    localparam int NUM_WORDS   = 10;
    localparam int SCALE_SHIFT = 15;

    localparam int ACCEL_FS_W  = 18;
    localparam int RATE_FS_W   = 22;
    localparam int ANGLE_FS_W  = 18;
    localparam int TEMP_OFS_W  = 18;
    localparam int ACCEL_W     = 19;
    localparam int RATE_W      = 23;
    localparam int ANGLE_W     = 19;
    localparam int TEMP_W      = 19;

    localparam int IN_TDATA_W  = 8;
    localparam int OUT_TDATA_W = 208;
    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;

    localparam logic [BYTE_W-1:0] SYNC_BYTE = 8'h55;
    localparam logic [BYTE_W-1:0] ID_ACCEL  = 8'h51;
    localparam logic [BYTE_W-1:0] ID_RATE   = 8'h52;
    localparam logic [BYTE_W-1:0] ID_ANGLE  = 8'h53;

    localparam int ACCEL_POS = 0;
    localparam int RATE_POS  = 11;
    localparam int ANGLE_POS = 22;

    // low byte position of each word in the 32-byte sequence
    localparam int WORD_LO [NUM_WORDS] = '{2, 4, 6, 13, 15, 17, 24, 26, 28, 30};

    // raw * 1000 / 340 == (|raw| * TEMP_RECIP) >> TEMP_SHIFT, exact for 16-bit raw
    localparam int              TEMP_RECIP_W = 26;
    localparam logic [25:0]     TEMP_RECIP   = 26'd49344753;
    localparam int              TEMP_SHIFT   = 24;
    localparam int              TEMP_Q_W     = 17;

    localparam logic [ACCEL_FS_W-1:0] ACCEL_FS_RST = 18'd156800;
    localparam logic [RATE_FS_W-1:0]  RATE_FS_RST  = 22'd2000000;
    localparam logic [ANGLE_FS_W-1:0] ANGLE_FS_RST = 18'd180000;
    localparam logic [TEMP_OFS_W-1:0] TEMP_OFS_RST = 18'd37000;

    typedef enum logic [1:0] {
        REG_ACCEL_FS = 2'd0,
        REG_RATE_FS  = 2'd1,
        REG_ANGLE_FS = 2'd2,
        REG_TEMP_OFS = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic ld2;
        logic ld3;
    } t_stage_en;

endpackage

// File: src/imu_sfd_cell.sv
// One byte cell of the receive window shift chain.
module imu_sfd_cell (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_shift,
    input  logic [imu_sfd_pkg::BYTE_W-1:0]  i_byte,
    output logic [imu_sfd_pkg::BYTE_W-1:0]  o_byte
);

    logic [imu_sfd_pkg::BYTE_W-1:0] r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte <= '0;
        end else if (i_shift) begin
            r_byte <= i_byte;
        end
    end

    assign o_byte = r_byte;

endmodule

// File: src/imu_sfd_scale.sv
// Scaling unit: signed word times full scale, arithmetic shift right by 15.
module imu_sfd_scale #(
    parameter int FS_W = imu_sfd_pkg::ACCEL_FS_W
) (
    input  logic                                i_clk,
    input  imu_sfd_pkg::t_stage_en              i_en,
    input  logic [imu_sfd_pkg::RAW_W-1:0]       i_raw,
    input  logic [FS_W-1:0]                     i_fs,
    output logic [FS_W:0]                       o_res
);

    localparam int PROD_W = FS_W + imu_sfd_pkg::RAW_W + 1;
    localparam int OUT_W  = FS_W + 1;

    logic signed [PROD_W-1:0] w_raw_x;
    logic signed [PROD_W-1:0] w_fs_x;
    logic signed [PROD_W-1:0] w_prod;
    logic        [PROD_W-1:0] r_prod;
    logic        [OUT_W-1:0]  r_res;

    assign w_raw_x = {{(PROD_W-imu_sfd_pkg::RAW_W){i_raw[imu_sfd_pkg::RAW_W-1]}}, i_raw};
    assign w_fs_x  = {{(PROD_W-FS_W){1'b0}}, i_fs};
    assign w_prod  = w_raw_x * w_fs_x;

    always_ff @(posedge i_clk) begin
        if (i_en.ld2) begin
            r_prod <= w_prod;
        end
        if (i_en.ld3) begin
            r_res <= r_prod[imu_sfd_pkg::SCALE_SHIFT+OUT_W-1:imu_sfd_pkg::SCALE_SHIFT];
        end
    end

    assign o_res = r_res;

endmodule

// File: src/imu_sfd_temp.sv
// Temperature unit: truncated raw*1000/340 plus a signed offset.
module imu_sfd_temp (
    input  logic                                    i_clk,
    input  imu_sfd_pkg::t_stage_en                  i_en,
    input  logic [imu_sfd_pkg::RAW_W-1:0]           i_raw,
    input  logic [imu_sfd_pkg::TEMP_OFS_W-1:0]      i_ofs,
    output logic [imu_sfd_pkg::TEMP_W-1:0]          o_res
);

    localparam int MAG_W  = imu_sfd_pkg::RAW_W;
    localparam int PROD_W = MAG_W + imu_sfd_pkg::TEMP_RECIP_W;
    localparam int OUT_W  = imu_sfd_pkg::TEMP_W;
    localparam int Q_W    = imu_sfd_pkg::TEMP_Q_W;

    logic [MAG_W-1:0]  w_mag;
    logic [PROD_W-1:0] w_prod;
    logic [Q_W-1:0]    r_q;
    logic              r_neg;
    logic [OUT_W-1:0]  w_q_x;
    logic [OUT_W-1:0]  w_signed_q;
    logic [OUT_W-1:0]  w_ofs_x;
    logic [OUT_W-1:0]  r_res;

    assign w_mag  = i_raw[MAG_W-1] ? (~i_raw + MAG_W'(1)) : i_raw;
    assign w_prod = {{(PROD_W-MAG_W){1'b0}}, w_mag}
                  * {{(PROD_W-imu_sfd_pkg::TEMP_RECIP_W){1'b0}}, imu_sfd_pkg::TEMP_RECIP};

    assign w_q_x      = {{(OUT_W-Q_W){1'b0}}, r_q};
    assign w_signed_q = r_neg ? (~w_q_x + OUT_W'(1)) : w_q_x;
    assign w_ofs_x    = {{(OUT_W-imu_sfd_pkg::TEMP_OFS_W){i_ofs[imu_sfd_pkg::TEMP_OFS_W-1]}},
                         i_ofs};

    always_ff @(posedge i_clk) begin
        if (i_en.ld2) begin
            r_q   <= w_prod[imu_sfd_pkg::TEMP_SHIFT+Q_W-1:imu_sfd_pkg::TEMP_SHIFT];
            r_neg <= i_raw[MAG_W-1];
        end
        if (i_en.ld3) begin
            r_res <= w_signed_q + w_ofs_x;
        end
    end

    assign o_res = r_res;

endmodule

// File: src/imu_serial_frame_decoder_top.sv
// IMU serial frame decoder: one received UART byte enters per transaction and
// shifts a chain of 31 byte cells. When the 32 bytes ending at the current byte
// hold the acceleration, angular rate and angle packets back to back, the ten
// raw words are captured; the nine motion words are multiplied by their full
// scale (the temperature is converted and offset) in one stage and registered
// as a result one stage later, driving the output. A byte is taken every cycle;
// the input stalls only when all three result stages hold undelivered results.
// The output tdata carries accel_x/y/z, rate_x/y/z, angle_x/y/z and temperature
// from the lowest bit up. Registers sit at byte addresses 0, 4, 8 and 12.
module imu_serial_frame_decoder_top (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    // stream input
    input  logic                                    i_s_axis_tvalid,
    output logic                                    o_s_axis_tready,
    input  logic [imu_sfd_pkg::IN_TDATA_W-1:0]      i_s_axis_tdata,  // [7:0] rx_byte
    // stream output
    output logic                                    o_m_axis_tvalid,
    input  logic                                    i_m_axis_tready,
    // [18:0] accel_x, [37:19] accel_y, [56:38] accel_z, [79:57] rate_x,
    // [102:80] rate_y, [125:103] rate_z, [144:126] angle_x, [163:145] angle_y,
    // [182:164] angle_z, [201:183] temperature, [207:202] zero
    output logic [imu_sfd_pkg::OUT_TDATA_W-1:0]     o_m_axis_tdata,
    // configuration
    input  logic                                    psel,
    input  logic                                    penable,
    input  logic                                    pwrite,
    input  logic [imu_sfd_pkg::APB_ADDR_W-1:0]      paddr,
    input  logic [imu_sfd_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [imu_sfd_pkg::APB_DATA_W-1:0]      prdata,
    output logic                                    pready
);

    `include "imu_serial_frame_decoder_top_defines.svh"

    localparam int BW = imu_sfd_pkg::BYTE_W;
    localparam int RW = imu_sfd_pkg::RAW_W;

    // configuration registers
    logic [imu_sfd_pkg::ACCEL_FS_W-1:0] r_accel_fs;
    logic [imu_sfd_pkg::RATE_FS_W-1:0]  r_rate_fs;
    logic [imu_sfd_pkg::ANGLE_FS_W-1:0] r_angle_fs;
    logic [imu_sfd_pkg::TEMP_OFS_W-1:0] r_temp_ofs;
    logic                               w_cfg_wr;
    imu_sfd_pkg::t_reg_idx              w_reg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;
    assign w_reg_idx = imu_sfd_pkg::t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_fs <= imu_sfd_pkg::ACCEL_FS_RST;
            r_rate_fs  <= imu_sfd_pkg::RATE_FS_RST;
            r_angle_fs <= imu_sfd_pkg::ANGLE_FS_RST;
            r_temp_ofs <= imu_sfd_pkg::TEMP_OFS_RST;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                imu_sfd_pkg::REG_ACCEL_FS: begin
                    r_accel_fs <= pwdata[imu_sfd_pkg::ACCEL_FS_W-1:0];
                end
                imu_sfd_pkg::REG_RATE_FS: begin
                    r_rate_fs <= pwdata[imu_sfd_pkg::RATE_FS_W-1:0];
                end
                imu_sfd_pkg::REG_ANGLE_FS: begin
                    r_angle_fs <= pwdata[imu_sfd_pkg::ANGLE_FS_W-1:0];
                end
                imu_sfd_pkg::REG_TEMP_OFS: begin
                    r_temp_ofs <= pwdata[imu_sfd_pkg::TEMP_OFS_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            imu_sfd_pkg::REG_ACCEL_FS: prdata = imu_sfd_pkg::APB_DATA_W'(r_accel_fs);
            imu_sfd_pkg::REG_RATE_FS:  prdata = imu_sfd_pkg::APB_DATA_W'(r_rate_fs);
            imu_sfd_pkg::REG_ANGLE_FS: prdata = imu_sfd_pkg::APB_DATA_W'(r_angle_fs);
            imu_sfd_pkg::REG_TEMP_OFS: prdata = imu_sfd_pkg::APB_DATA_W'(r_temp_ofs);
            default:                   prdata = '0;
        endcase
    end

    // stage handshake
    logic r_v1, r_v2, r_v3;
    logic n_v1, n_v2, n_v3;
    logic w_rdy1, w_rdy2, w_rdy3;
    logic w_acc, w_hit, w_ld1;
    imu_sfd_pkg::t_stage_en w_en;

    assign w_rdy3          = !r_v3 || i_m_axis_tready;
    assign w_rdy2          = !r_v2 || w_rdy3;
    assign w_rdy1          = !r_v1 || w_rdy2;
    assign o_s_axis_tready = w_rdy1;
    assign w_acc           = i_s_axis_tvalid && w_rdy1;
    assign w_ld1           = w_acc && w_hit;
    assign w_en.ld2        = r_v1 && w_rdy2;
    assign w_en.ld3        = r_v2 && w_rdy3;
    assign o_m_axis_tvalid = r_v3;

    always_comb begin
        n_v1 = w_ld1 ? 1'b1 : (w_en.ld2 ? 1'b0 : r_v1);
        n_v2 = w_en.ld2 ? 1'b1 : (w_en.ld3 ? 1'b0 : r_v2);
        n_v3 = w_en.ld3 ? 1'b1 : (i_m_axis_tready ? 1'b0 : r_v3);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
            r_v3 <= n_v3;
        end
    end

    // byte window: cell 0 is the oldest byte
    logic [BW-1:0] w_win [imu_sfd_pkg::WIN_DEPTH];
    logic [BW-1:0] w_s   [imu_sfd_pkg::SEQ_LEN];

    for (genvar i = 0; i < imu_sfd_pkg::WIN_DEPTH; i++) begin : g_cell
        logic [BW-1:0] w_next;
        if (i == imu_sfd_pkg::WIN_DEPTH - 1) begin : g_head
            assign w_next = i_s_axis_tdata;
        end else begin : g_body
            assign w_next = w_win[i+1];
        end
        imu_sfd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (w_acc),
            .i_byte  (w_next),
            .o_byte  (w_win[i])
        );
        assign w_s[i] = w_win[i];
    end
    assign w_s[imu_sfd_pkg::SEQ_LEN-1] = i_s_axis_tdata;

    assign w_hit = (w_s[imu_sfd_pkg::ACCEL_POS]   == imu_sfd_pkg::SYNC_BYTE)
                && (w_s[imu_sfd_pkg::ACCEL_POS+1] == imu_sfd_pkg::ID_ACCEL)
                && (w_s[imu_sfd_pkg::RATE_POS]    == imu_sfd_pkg::SYNC_BYTE)
                && (w_s[imu_sfd_pkg::RATE_POS+1]  == imu_sfd_pkg::ID_RATE)
                && (w_s[imu_sfd_pkg::ANGLE_POS]   == imu_sfd_pkg::SYNC_BYTE)
                && (w_s[imu_sfd_pkg::ANGLE_POS+1] == imu_sfd_pkg::ID_ANGLE);

    // capture stage
    logic [RW-1:0] r_raw [imu_sfd_pkg::NUM_WORDS];

    for (genvar k = 0; k < imu_sfd_pkg::NUM_WORDS; k++) begin : g_cap
        always_ff @(posedge i_clk) begin
            if (w_ld1) begin
                r_raw[k] <= {w_s[imu_sfd_pkg::WORD_LO[k]+1], w_s[imu_sfd_pkg::WORD_LO[k]]};
            end
        end
    end

    // scaling units
    logic [imu_sfd_pkg::ACCEL_W-1:0] w_accel [3];
    logic [imu_sfd_pkg::RATE_W-1:0]  w_rate  [3];
    logic [imu_sfd_pkg::ANGLE_W-1:0] w_angle [3];
    logic [imu_sfd_pkg::TEMP_W-1:0]  w_temp;

    for (genvar k = 0; k < 3; k++) begin : g_axis
        imu_sfd_scale #(.FS_W(imu_sfd_pkg::ACCEL_FS_W)) u_accel (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_raw (r_raw[k]),
            .i_fs  (r_accel_fs),
            .o_res (w_accel[k])
        );
        imu_sfd_scale #(.FS_W(imu_sfd_pkg::RATE_FS_W)) u_rate (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_raw (r_raw[3+k]),
            .i_fs  (r_rate_fs),
            .o_res (w_rate[k])
        );
        imu_sfd_scale #(.FS_W(imu_sfd_pkg::ANGLE_FS_W)) u_angle (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_raw (r_raw[6+k]),
            .i_fs  (r_angle_fs),
            .o_res (w_angle[k])
        );
    end

    imu_sfd_temp u_temp (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_raw (r_raw[imu_sfd_pkg::NUM_WORDS-1]),
        .i_ofs (r_temp_ofs),
        .o_res (w_temp)
    );

    assign o_m_axis_tdata = {6'b0, w_temp,
                             w_angle[2], w_angle[1], w_angle[0],
                             w_rate[2], w_rate[1], w_rate[0],
                             w_accel[2], w_accel[1], w_accel[0]};

    // assertions
    `SFD_ASSERT_IMPL(a_stall_full, i_clk, i_rst_n, !o_s_axis_tready,
        r_v1 && r_v2 && r_v3 && !i_m_axis_tready, "input stalled with a free stage")
    `SFD_ASSERT_NEXT(a_hit_loads, i_clk, i_rst_n, w_acc && w_hit, r_v1,
        "frame match not captured")
    `SFD_ASSERT_NEXT(a_win_shift, i_clk, i_rst_n, w_acc,
        w_win[imu_sfd_pkg::WIN_DEPTH-1] == $past(i_s_axis_tdata),
        "accepted byte missing from window head")

endmodule

// File: bench/imu_serial_frame_decoder_checker.sv
`timescale 1ns / 1ps
// Checker for the IMU frame decoder: tracks bytes and register writes, predicts readings, compares.
module imu_serial_frame_decoder_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_axis_tvalid,
    input  logic                                i_s_axis_tready,
    input  logic [imu_sfd_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    input  logic                                i_m_axis_tvalid,
    input  logic                                i_m_axis_tready,
    input  logic [imu_sfd_pkg::OUT_TDATA_W-1:0] i_m_axis_tdata,
    input  logic                                i_psel,
    input  logic                                i_penable,
    input  logic                                i_pwrite,
    input  logic [imu_sfd_pkg::APB_ADDR_W-1:0]  i_paddr,
    input  logic [imu_sfd_pkg::APB_DATA_W-1:0]  i_pwdata,
    input  logic                                i_pready,
    output int                                  o_fail_count,
    output int                                  o_pending
);
    import imu_sfd_pkg::*;

    localparam int NUM_FIELDS = NUM_WORDS + 1;
    localparam int PAD_W      = OUT_TDATA_W - (3 * ACCEL_W + 3 * RATE_W + 3 * ANGLE_W + TEMP_W);
    localparam int FIELD_W [NUM_FIELDS] = '{ACCEL_W, ACCEL_W, ACCEL_W, RATE_W, RATE_W, RATE_W,
                                            ANGLE_W, ANGLE_W, ANGLE_W, TEMP_W, PAD_W};
    localparam string FIELD_NAME [NUM_FIELDS] = '{"accel_x", "accel_y", "accel_z",
                                                  "rate_x", "rate_y", "rate_z",
                                                  "angle_x", "angle_y", "angle_z",
                                                  "temperature", "pad"};
    localparam longint TEMP_MUL = 1000;
    localparam longint TEMP_DIV = 340;

    logic [ACCEL_FS_W-1:0]        accel_fs;
    logic [RATE_FS_W-1:0]         rate_fs;
    logic [ANGLE_FS_W-1:0]        angle_fs;
    logic signed [TEMP_OFS_W-1:0] temp_ofs;
    logic [WIN_DEPTH*BYTE_W-1:0]  byte_hist;
    logic [OUT_TDATA_W-1:0]       pending_readings [$];

    function automatic longint raw_word(input logic [SEQ_LEN*BYTE_W-1:0] seq, input int lo);
        logic signed [RAW_W-1:0] w;
        begin
            w = {seq[BYTE_W*(lo+1) +: BYTE_W], seq[BYTE_W*lo +: BYTE_W]};
            return longint'(w);
        end
    endfunction

    function automatic logic frame_hit(input logic [SEQ_LEN*BYTE_W-1:0] seq);
        return seq[BYTE_W*ACCEL_POS +: BYTE_W] == SYNC_BYTE &&
               seq[BYTE_W*(ACCEL_POS+1) +: BYTE_W] == ID_ACCEL &&
               seq[BYTE_W*RATE_POS +: BYTE_W] == SYNC_BYTE &&
               seq[BYTE_W*(RATE_POS+1) +: BYTE_W] == ID_RATE &&
               seq[BYTE_W*ANGLE_POS +: BYTE_W] == SYNC_BYTE &&
               seq[BYTE_W*(ANGLE_POS+1) +: BYTE_W] == ID_ANGLE;
    endfunction

    // floor(raw * fs / 2^15) for the nine motion words, truncated temperature plus offset
    function automatic logic [OUT_TDATA_W-1:0] decode_window(
        input logic [SEQ_LEN*BYTE_W-1:0] seq
    );
        longint                 v;
        longint                 fs;
        int                     lo;
        logic [OUT_TDATA_W-1:0] part;
        logic [OUT_TDATA_W-1:0] reading;
        begin
            reading = '0;
            lo = 0;
            for (int k = 0; k < NUM_WORDS; k++) begin
                if (k == NUM_WORDS - 1) begin
                    v = (raw_word(seq, WORD_LO[k]) * TEMP_MUL) / TEMP_DIV + longint'(temp_ofs);
                end else begin
                    case (k / 3)
                        0:       fs = longint'(accel_fs);
                        1:       fs = longint'(rate_fs);
                        default: fs = longint'(angle_fs);
                    endcase
                    v = (raw_word(seq, WORD_LO[k]) * fs) >>> SCALE_SHIFT;
                end
                part = OUT_TDATA_W'(v & ((longint'(1) << FIELD_W[k]) - 1));
                reading = reading | (part << lo);
                lo += FIELD_W[k];
            end
            return reading;
        end
    endfunction

    function automatic logic [RATE_W-1:0] field_of(input logic [OUT_TDATA_W-1:0] r, input int k);
        int lo;
        begin
            lo = 0;
            for (int i = 0; i < k; i++) lo += FIELD_W[i];
            return RATE_W'((r >> lo) & ((OUT_TDATA_W'(1) << FIELD_W[k]) - 1));
        end
    endfunction

    always @(posedge i_clk) begin : l_monitor
        logic [SEQ_LEN*BYTE_W-1:0] seq;
        logic [OUT_TDATA_W-1:0]    want;
        if (!i_rst_n) begin
            accel_fs = ACCEL_FS_RST;
            rate_fs = RATE_FS_RST;
            angle_fs = ANGLE_FS_RST;
            temp_ofs = TEMP_OFS_RST;
            byte_hist = '0;
            pending_readings.delete();
            o_fail_count = 0;
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[APB_ADDR_W-1:2]))
                    REG_ACCEL_FS: accel_fs = i_pwdata[ACCEL_FS_W-1:0];
                    REG_RATE_FS:  rate_fs = i_pwdata[RATE_FS_W-1:0];
                    REG_ANGLE_FS: angle_fs = i_pwdata[ANGLE_FS_W-1:0];
                    REG_TEMP_OFS: temp_ofs = i_pwdata[TEMP_OFS_W-1:0];
                endcase
            end
            if (i_m_axis_tvalid && i_m_axis_tready) begin
                if (pending_readings.size() == 0) begin
                    $display("%0t: unexpected reading, expected none, actual %h",
                             $time, i_m_axis_tdata);
                    o_fail_count++;
                end else begin
                    want = pending_readings.pop_front();
                    for (int k = 0; k < NUM_FIELDS; k++) begin
                        if (field_of(i_m_axis_tdata, k) !== field_of(want, k)) begin
                            $display("%0t: %s mismatch, expected %h, actual %h", $time,
                                     FIELD_NAME[k], field_of(want, k),
                                     field_of(i_m_axis_tdata, k));
                            o_fail_count++;
                        end
                    end
                end
            end
            if (i_s_axis_tvalid && i_s_axis_tready) begin
                seq = {i_s_axis_tdata, byte_hist};
                if (frame_hit(seq)) pending_readings.push_back(decode_window(seq));
                byte_hist = seq[SEQ_LEN*BYTE_W-1:BYTE_W];
            end
        end
        o_pending = pending_readings.size();
    end

endmodule

// File: bench/imu_serial_frame_decoder_top_test.sv
`timescale 1ns / 1ps
// Testbench top for the IMU frame decoder: drives bytes, register writes and gives the verdict.
module imu_serial_frame_decoder_top_test;
    import imu_sfd_pkg::*;

    localparam int CLK_HALF      = 4;
    localparam int RANDOM_BYTES  = 1020;
    localparam int NUM_PHASES    = 6;
    localparam int SETTLE_CYCLES = 10;
    localparam int FRAME_BYTES   = SEQ_LEN + 1;  // three packets with the final checksum
    localparam int OVERLAP_SHIFT = 2;
    localparam int OVERLAP_BYTES = FRAME_BYTES + OVERLAP_SHIFT;
    localparam int RUN_LIMIT_NS  = 2000000;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_valid;
    logic                   s_ready;
    logic [IN_TDATA_W-1:0]  s_data;
    logic                   m_valid;
    logic                   m_ready;
    logic [OUT_TDATA_W-1:0] m_data;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;
    int                     fail_count;
    int                     pending;
    bit                     idle_on;
    int                     bytes_sent;

    imu_serial_frame_decoder_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    imu_serial_frame_decoder_checker u_check (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .i_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .i_m_axis_tdata  (m_data),
        .i_psel          (psel),
        .i_penable       (penable),
        .i_pwrite        (pwrite),
        .i_paddr         (paddr),
        .i_pwdata        (pwdata),
        .i_pready        (pready),
        .o_fail_count    (fail_count),
        .o_pending       (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin
        #RUN_LIMIT_NS;
        $display("RESULT: ERROR");
        $finish;
    end

    // receiver back-pressure in bursts
    initial begin
        m_ready = 1'b1;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (idle_on && $urandom_range(0, 3) == 0) begin
                m_ready = 1'b0;
                repeat ($urandom_range(1, 18)) @(negedge i_clk);
            end
            m_ready = 1'b1;
            repeat ($urandom_range(1, 24)) @(negedge i_clk);
        end
    end

    task automatic send_byte(input logic [BYTE_W-1:0] b);
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 18)) @(negedge i_clk);
        end
        s_valid = 1'b1;
        s_data = b;
        do @(posedge i_clk); while (!s_ready);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    // stop sending and let every pending reading come out
    task automatic drain();
        s_valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [APB_DATA_W-1:0] val);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = APB_ADDR_W'({idx, 2'b00});
        pwdata = val;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    function automatic logic [RAW_W-1:0] pick_word();
        if ($urandom_range(0, 4) != 0) return RAW_W'($urandom());
        case ($urandom_range(0, 4))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'h0001;
        endcase
    endfunction

    function automatic logic [NUM_WORDS*RAW_W-1:0] pick_words();
        logic [NUM_WORDS*RAW_W-1:0] w;
        begin
            for (int k = 0; k < NUM_WORDS; k++) w[RAW_W*k +: RAW_W] = pick_word();
            return w;
        end
    endfunction

    task automatic send_frame(input logic [NUM_WORDS*RAW_W-1:0] words, input bit broken);
        logic [FRAME_BYTES*BYTE_W-1:0] fb;
        int                            idx;
        int                            p;
        for (int i = 0; i < FRAME_BYTES; i++) fb[BYTE_W*i +: BYTE_W] = BYTE_W'($urandom());
        fb[BYTE_W*ACCEL_POS +: 2*BYTE_W] = {ID_ACCEL, SYNC_BYTE};
        fb[BYTE_W*RATE_POS +: 2*BYTE_W]  = {ID_RATE, SYNC_BYTE};
        fb[BYTE_W*ANGLE_POS +: 2*BYTE_W] = {ID_ANGLE, SYNC_BYTE};
        for (int k = 0; k < NUM_WORDS; k++)
            fb[BYTE_W*WORD_LO[k] +: RAW_W] = words[RAW_W*k +: RAW_W];
        if (broken) begin
            idx = $urandom_range(0, 5);
            case (idx / 2)
                0:       p = ACCEL_POS + idx % 2;
                1:       p = RATE_POS + idx % 2;
                default: p = ANGLE_POS + idx % 2;
            endcase
            fb[BYTE_W*p +: BYTE_W] = fb[BYTE_W*p +: BYTE_W] ^ BYTE_W'($urandom_range(1, 255));
        end
        for (int i = 0; i < FRAME_BYTES; i++) send_byte(fb[BYTE_W*i +: BYTE_W]);
    endtask

    // second frame starts inside the first one's acceleration data
    task automatic send_overlap();
        logic [OVERLAP_BYTES*BYTE_W-1:0] fb;
        for (int i = 0; i < OVERLAP_BYTES; i++) fb[BYTE_W*i +: BYTE_W] = BYTE_W'($urandom());
        for (int s = 0; s <= OVERLAP_SHIFT; s += OVERLAP_SHIFT) begin
            fb[BYTE_W*(ACCEL_POS+s) +: 2*BYTE_W] = {ID_ACCEL, SYNC_BYTE};
            fb[BYTE_W*(RATE_POS+s) +: 2*BYTE_W]  = {ID_RATE, SYNC_BYTE};
            fb[BYTE_W*(ANGLE_POS+s) +: 2*BYTE_W] = {ID_ANGLE, SYNC_BYTE};
        end
        for (int i = 0; i < OVERLAP_BYTES; i++) send_byte(fb[BYTE_W*i +: BYTE_W]);
    endtask

    task automatic send_noise();
        repeat ($urandom_range(1, 8))
            send_byte($urandom_range(0, 2) == 0 ? SYNC_BYTE : BYTE_W'($urandom()));
    endtask

    task automatic configure(input int phase);
        case (phase)
            1: begin
                write_reg(REG_ACCEL_FS, 32'd262143);
                write_reg(REG_RATE_FS, 32'd4194303);
                write_reg(REG_ANGLE_FS, 32'd262143);
                write_reg(REG_TEMP_OFS, 32'd100000);
            end
            2: begin
                write_reg(REG_ACCEL_FS, 32'd0);
                write_reg(REG_RATE_FS, 32'd0);
                write_reg(REG_ANGLE_FS, 32'd0);
                write_reg(REG_TEMP_OFS, APB_DATA_W'(-100000));
            end
            4: begin
                write_reg(REG_ACCEL_FS, $urandom());
                write_reg(REG_RATE_FS, $urandom());
                write_reg(REG_ANGLE_FS, $urandom());
                write_reg(REG_TEMP_OFS, $urandom());
            end
            default: begin
                write_reg(REG_ACCEL_FS, $urandom_range(0, 262143));
                write_reg(REG_RATE_FS, $urandom_range(0, 4194303));
                write_reg(REG_ANGLE_FS, $urandom_range(0, 262143));
                write_reg(REG_TEMP_OFS, APB_DATA_W'(int'($urandom_range(0, 200000)) - 100000));
            end
        endcase
    endtask

    initial begin
        int target;
        i_rst_n = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        idle_on = 1'b1;
        bytes_sent = 0;
        repeat (2) @(negedge i_clk);
        i_rst_n = 1'b1;

        // start-up: angle packet alone against a zeroed window
        send_byte(SYNC_BYTE);
        send_byte(ID_ANGLE);
        repeat (9) send_byte(BYTE_W'($urandom()));
        send_frame({NUM_WORDS{16'h8000}}, 1'b0);
        send_frame({NUM_WORDS{16'h7FFF}}, 1'b0);
        send_frame({NUM_WORDS{16'h0000}}, 1'b0);
        send_frame({NUM_WORDS{16'hFFFF}}, 1'b0);
        send_frame({NUM_WORDS/2{32'h7FFF_8000}}, 1'b0);
        send_overlap();
        send_frame(pick_words(), 1'b1);
        send_frame(pick_words(), 1'b0);
        drain();

        bytes_sent = 0;
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            if (phase > 0) begin
                drain();
                configure(phase);
            end
            if (phase == NUM_PHASES - 1) idle_on = 1'b0;
            target = RANDOM_BYTES * (phase + 1) / NUM_PHASES;
            while (bytes_sent < target) begin
                case ($urandom_range(0, 9))
                    0:       send_noise();
                    1:       send_frame(pick_words(), 1'b1);
                    default: send_frame(pick_words(), 1'b0);
                endcase
                if (phase == 3 && $urandom_range(0, 15) == 0) drain();
            end
        end

        drain();
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// File: imu_serial_frame_decoder_top.f
+incdir+src
src/imu_sfd_pkg.sv
src/imu_sfd_cell.sv
src/imu_sfd_scale.sv
src/imu_sfd_temp.sv
src/imu_serial_frame_decoder_top.sv
bench/imu_serial_frame_decoder_checker.sv
bench/imu_serial_frame_decoder_top_test.sv
